[hw/rtl/sma_pkg.sv]
// shared types and constants for the stack machine execution unit
package sma_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int OPC_W       = 5;
    localparam int STAT_W      = 3;
    localparam int COUNT_W     = 9;
    localparam int DIV_STEPS   = WORD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int MIN_OPERANDS = 2;

    localparam logic signed [OPC_W-1:0] OP_IDLE = -5'sd1;
    localparam logic signed [OPC_W-1:0] OP_PUSH = 5'sd0;
    localparam logic signed [OPC_W-1:0] OP_ADD  = 5'sd1;
    localparam logic signed [OPC_W-1:0] OP_SUB  = 5'sd2;
    localparam logic signed [OPC_W-1:0] OP_MUL  = 5'sd3;
    localparam logic signed [OPC_W-1:0] OP_DIV  = 5'sd4;
    localparam logic signed [OPC_W-1:0] OP_EQ   = 5'sd5;
    localparam logic signed [OPC_W-1:0] OP_NEQ  = 5'sd6;
    localparam logic signed [OPC_W-1:0] OP_LT   = 5'sd7;
    localparam logic signed [OPC_W-1:0] OP_LTE  = 5'sd8;
    localparam logic signed [OPC_W-1:0] OP_GT   = 5'sd9;
    localparam logic signed [OPC_W-1:0] OP_GTE  = 5'sd10;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic signed [OPC_W-1:0]  opcode;
        logic signed [WORD_W-1:0] push_value;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] returned_value;
        logic signed [WORD_W-1:0] top_value;
        logic [COUNT_W-1:0]       stack_count;
    } t_out_beat;

endpackage

[hw/rtl/sma_stack_ram.sv]
// stack word memory: one write port, one registered read port
module sma_stack_ram (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [sma_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [sma_pkg::WORD_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [sma_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [sma_pkg::WORD_W-1:0]   o_rd_data
);
    import sma_pkg::*;

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/sma_divider.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module sma_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [sma_pkg::WORD_W-1:0]   i_dividend,
    input  logic signed [sma_pkg::WORD_W-1:0]   i_divisor,
    output logic                                o_done,
    output logic signed [sma_pkg::WORD_W-1:0]   o_quotient
);
    import sma_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0]    r_rem, n_rem;
    logic [WORD_W-1:0]    r_quo, n_quo;
    logic [WORD_W-1:0]    r_dvs, n_dvs;
    logic                 r_neg, n_neg;
    logic [WORD_W:0]      w_trial;
    logic [WORD_W:0]      w_diff;

    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = DIV_CNT_W'(DIV_STEPS - 1);
            n_rem  = '0;
            // magnitudes; the minimum word maps onto itself as unsigned
            n_quo  = i_dividend[WORD_W-1] ? WORD_W'(-i_dividend) : WORD_W'(i_dividend);
            n_dvs  = i_divisor[WORD_W-1] ? WORD_W'(-i_divisor) : WORD_W'(i_divisor);
            n_neg  = i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            if (!w_diff[WORD_W]) begin
                n_rem = w_diff[WORD_W-1:0];
                n_quo = {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[WORD_W-1:0];
                n_quo = {r_quo[WORD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? WORD_W'(-r_quo) : r_quo;

endmodule

[hw/rtl/stack_machine_alu.sv]
// stack machine execution unit: sequencer, top-of-stack register and result beat
//
// Each input beat is one instruction. The stack words live in a synchronous memory;
// the top word is also held in a register, so a two-operand instruction reads only
// the second word, one memory read per instruction. Idle, push, add, sub, mul, the
// comparisons and every error are accepted together with the memory read, then
// executed and written back. Div is instead handed to the bit-serial divider,
// which produces one quotient bit per cycle. The memory needs no clearing after
// reset. One instruction is in flight at a time; a result beat waits in the output
// register while the next instruction is accepted and worked on.
module stack_machine_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sma_pkg::t_in_beat    i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sma_pkg::t_out_beat   o_out_beat
);
    import sma_pkg::*;

    t_state                   r_state, n_state;
    logic signed [OPC_W-1:0]  r_op, n_op;
    logic signed [WORD_W-1:0] r_pv, n_pv;
    logic [SP_W-1:0]          r_sp, n_sp;
    logic signed [WORD_W-1:0] r_top, n_top;
    t_out_beat                r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_finish;
    logic [STAT_W-1:0]        w_status;
    logic signed [WORD_W-1:0] w_ret;
    logic signed [WORD_W-1:0] w_res;
    logic signed [WORD_W-1:0] w_left;
    logic signed [WORD_W-1:0] w_mul;
    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic [WORD_W-1:0]        w_rd_data;
    logic                     w_wr_en;
    logic [ADDR_W-1:0]        w_wr_addr;
    logic [WORD_W-1:0]        w_wr_data;
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [WORD_W-1:0] w_div_quo;
    logic                     w_two_words;
    logic [SP_W-1:0]          w_sp_m2;

    sma_stack_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    sma_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_left),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_left      = w_rd_data;
    assign w_mul       = w_left * r_top;
    assign w_two_words = (r_sp >= SP_W'(MIN_OPERANDS));
    assign w_sp_m2     = r_sp - SP_W'(MIN_OPERANDS);

    // second word from the top is fetched as the beat is taken
    assign w_rd_en   = w_accept;
    assign w_rd_addr = w_sp_m2[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pv        = r_pv;
        n_sp        = r_sp;
        n_top       = r_top;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_finish    = 1'b0;
        w_status    = ST_OK;
        w_ret       = '0;
        w_res       = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_sp_m2[ADDR_W-1:0];
        w_wr_data   = '0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_in_beat.opcode;
                    n_pv    = i_in_beat.push_value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_finish = w_out_free;
                case (r_op)
                    OP_IDLE: begin
                    end
                    OP_PUSH: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            w_status = ST_OVERFLOW;
                        end else if (w_finish) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_sp[ADDR_W-1:0];
                            w_wr_data = r_pv;
                            n_sp      = r_sp + SP_W'(1);
                            n_top     = r_pv;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NEQ,
                    OP_LT, OP_LTE, OP_GT, OP_GTE: begin
                        if (!w_two_words) begin
                            w_status = ST_UNDERFLOW;
                        end else if (r_op == OP_DIV) begin
                            if (r_top == '0) begin
                                w_status = ST_DIVZERO;
                            end else begin
                                // divider runs regardless of the output side
                                w_finish    = 1'b0;
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end else begin
                            case (r_op)
                                OP_ADD:  w_res = w_left + r_top;
                                OP_SUB:  w_res = w_left - r_top;
                                OP_MUL:  w_res = w_mul;
                                OP_EQ:   w_res = WORD_W'(w_left == r_top);
                                OP_NEQ:  w_res = WORD_W'(w_left != r_top);
                                OP_LT:   w_res = WORD_W'(w_left < r_top);
                                OP_LTE:  w_res = WORD_W'(w_left <= r_top);
                                OP_GT:   w_res = WORD_W'(w_left > r_top);
                                default: w_res = WORD_W'(w_left >= r_top);
                            endcase
                            if (r_op inside {OP_ADD, OP_SUB, OP_MUL}) begin
                                w_ret = w_res;
                            end
                            if (w_finish) begin
                                w_wr_en   = 1'b1;
                                w_wr_data = w_res;
                                n_sp      = r_sp - SP_W'(1);
                                n_top     = w_res;
                            end
                        end
                    end
                    default: begin
                        w_status = ST_UNKNOWN;
                    end
                endcase
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                w_finish = w_div_done && w_out_free;
                w_ret    = w_div_quo;
                if (w_finish) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_div_quo;
                    n_sp      = r_sp - SP_W'(1);
                    n_top     = w_div_quo;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_finish) begin
            n_out.status         = w_status;
            n_out.returned_value = w_ret;
            n_out.top_value      = (n_sp != '0) ? n_top : '0;
            n_out.stack_count    = COUNT_W'(n_sp);
            n_out_valid          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_pv  <= n_pv;
        r_top <= n_top;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
